// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the decompressor RTL.
// Each check runs on the rising edge of clk and is quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== rtl/core/lzd_pkg.sv =====
// Package for the mask/link LZ decompressor: element kinds, error codes, widths
// and the command word passed from the front to the back. No dependencies.
`timescale 1ns / 1ps
package lzd_pkg;

  localparam int HISTORY_DEPTH_DEF    = 4096;
  localparam int BYTES_PER_RESULT_DEF = 8;

  localparam int OSIZE_W = 25;  // output size and produced count
  localparam int DIST_W  = 13;  // distance 1..4096
  localparam int REM_W   = 9;   // bytes left in one run, up to 273
  localparam int DATA_W  = 64;

  // Element kinds
  localparam logic [1:0] KIND_MASK  = 2'd0;
  localparam logic [1:0] KIND_LIT   = 2'd1;
  localparam logic [1:0] KIND_LINK  = 2'd2;
  localparam logic [1:0] KIND_COUNT = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_KIND = 2'd1;
  localparam logic [1:0] ERR_DIST = 2'd2;

  // Classified element
  typedef struct packed {
    logic [1:0]        op;
    logic [31:0]       word;
    logic [DIST_W-1:0] link_dist;
    logic [3:0]        nib;
  } cmd_t;

endpackage

// ===== rtl/core/lzd_item_if.sv =====
// Input channel of the decompressor: one stream element per beat.
// Depends on nothing.
`timescale 1ns / 1ps
interface lzd_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

// ===== rtl/core/lzd_result_if.sv =====
// Result channel of the decompressor: up to eight decoded bytes and status per beat.
// Depends on nothing.
`timescale 1ns / 1ps
interface lzd_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_bytes;
  logic [3:0]  byte_count;
  logic        last_of_run;
  logic [1:0]  next_kind;
  logic        done_res;
  logic [1:0]  error;

  modport source (output valid, output data_bytes, output byte_count, output last_of_run,
                  output next_kind, output done_res, output error, input ready);
  modport sink (input valid, input data_bytes, input byte_count, input last_of_run,
                input next_kind, input done_res, input error, output ready);
endinterface

// ===== rtl/core/lzd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/lzd_front.sv =====
// Front of the decompressor: takes stream elements, splits link fields and
// queues them in a two-entry command queue. Depends on lzd_pkg, lzd_item_if.
`timescale 1ns / 1ps
module lzd_front import lzd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  lzd_item_if.sink   item,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_pop
);

  cmd_t       queue [2];
  cmd_t       cmd_in;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  // Classify the element: distance and length nibble of a link
  always_comb begin
    cmd_in.op        = item.op;
    cmd_in.word      = item.value;
    cmd_in.link_dist = {1'b0, item.value[11:0]} + DIST_W'(1);
    cmd_in.nib       = item.value[15:12];
  end

  assign item.ready = (count != 2'd2);
  assign push       = item.valid && item.ready;
  assign cmd        = queue[rd_ptr];
  assign cmd_valid  = (count != 2'd0);

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

endmodule

// ===== rtl/core/lzd_back.sv =====
// Back of the decompressor: runs each command against the decode state, copies
// from the history RAM and packs bytes into result beats.
// Depends on lzd_pkg, lzd_result_if, lzd_ram, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lzd_back import lzd_pkg::*; #(
  parameter int HISTORY_DEPTH    = HISTORY_DEPTH_DEF,
  parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [OSIZE_W-1:0] cfg_wdata,
  input  cmd_t               cmd,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  lzd_result_if.source       result
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]         state;
  logic [OSIZE_W-1:0] output_size;
  logic [OSIZE_W-1:0] produced;
  logic [31:0]        mask_bits;
  logic [5:0]         mask_left;
  logic [DIST_W-1:0]  pending_dist;
  logic [1:0]         expect_kind;
  logic               finished;
  logic [AW-1:0]      copy_addr;
  logic [REM_W-1:0]   rem;
  logic               is_lit;
  logic [7:0]         lit_val;
  logic [DATA_W-1:0]  pack_data;
  logic [3:0]         pack_cnt;
  logic               run_last;
  logic [1:0]         res_kind;
  logic               res_done;
  logic [1:0]         res_err;
  logic               out_valid;
  logic               out_load;

  // Decode results
  logic [OSIZE_W-1:0] room;
  logic [REM_W-1:0]   len_raw;
  logic [DIST_W-1:0]  dist_sel;
  logic [REM_W-1:0]   d_n;
  logic [1:0]         d_err;
  logic               d_use;
  logic               d_lit;
  logic [31:0]        mask_next;
  logic [5:0]         mask_left_next;
  logic [DIST_W-1:0]  pending_dist_next;
  logic [1:0]         expect_kind_next;
  logic               finished_next;

  logic [7:0]         ram_rdata;
  logic [7:0]         wr_byte;
  logic               ram_we;
  logic               ram_re;

  // Decode the head command against the current state
  always_comb begin
    room     = (output_size > produced) ? (output_size - produced) : '0;
    len_raw  = (cmd.op == KIND_LINK) ? (REM_W'(cmd.nib) + REM_W'(2))
                                     : (REM_W'(cmd.word[7:0]) + REM_W'(18));
    dist_sel = (cmd.op == KIND_LINK) ? cmd.link_dist : pending_dist;
    d_n               = '0;
    d_err             = ERR_NONE;
    d_use             = 1'b0;
    d_lit             = 1'b0;
    mask_next         = mask_bits;
    mask_left_next    = mask_left;
    pending_dist_next = pending_dist;
    expect_kind_next  = expect_kind;
    finished_next     = finished;
    if (finished) begin
      d_n = '0;
    end else if (cmd.op != expect_kind) begin
      d_err = ERR_KIND;
    end else begin
      unique case (cmd.op)
        KIND_MASK: begin
          mask_next        = cmd.word;
          mask_left_next   = 6'd32;
          expect_kind_next = cmd.word[31] ? KIND_LIT : KIND_LINK;
        end
        KIND_LIT: begin
          d_n   = (room != '0) ? REM_W'(1) : '0;
          d_lit = 1'b1;
          d_use = 1'b1;
        end
        KIND_LINK, KIND_COUNT: begin
          if ((cmd.op == KIND_LINK) && (cmd.nib == 4'd0)) begin
            pending_dist_next = cmd.link_dist;
            expect_kind_next  = KIND_COUNT;
          end else begin
            d_use = 1'b1;
            if ((dist_sel == '0) || (OSIZE_W'(dist_sel) > produced)) begin
              d_err = ERR_DIST;
            end else begin
              d_n = (OSIZE_W'(len_raw) > room) ? room[REM_W-1:0] : len_raw;
            end
          end
        end
        default: begin
          d_n = '0;
        end
      endcase
      // Consume one mask bit; the run never goes past room, so equality means finish
      if (d_use) begin
        mask_next        = mask_bits << 1;
        mask_left_next   = (mask_left != 6'd0) ? (mask_left - 6'd1) : 6'd0;
        expect_kind_next = (mask_left_next == 6'd0) ? KIND_MASK
                         : (mask_next[31] ? KIND_LIT : KIND_LINK);
        finished_next    = (OSIZE_W'(d_n) == room);
      end
    end
  end

  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign out_load = (state == S_FLUSH) && (!out_valid || result.ready);
  assign wr_byte  = is_lit ? lit_val : ram_rdata;
  assign ram_we   = (state == S_WRITE);
  assign ram_re   = (state == S_READ);

  lzd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (produced[AW-1:0]),
    .wdata (wr_byte),
    .re    (ram_re),
    .raddr (copy_addr),
    .rdata (ram_rdata)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      output_size <= '0;
    end else if (cfg_we) begin
      output_size <= cfg_wdata;
    end
  end

  // Sequencer and decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      produced     <= '0;
      mask_bits    <= '0;
      mask_left    <= '0;
      pending_dist <= '0;
      expect_kind  <= KIND_MASK;
      finished     <= 1'b0;
      rem          <= '0;
      pack_cnt     <= '0;
      pack_data    <= '0;
      run_last     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            mask_bits    <= mask_next;
            mask_left    <= mask_left_next;
            pending_dist <= pending_dist_next;
            expect_kind  <= expect_kind_next;
            finished     <= finished_next;
            rem          <= d_n;
            if (d_n == '0) begin
              run_last <= 1'b1;
              state    <= S_FLUSH;
            end else begin
              run_last <= 1'b0;
              state    <= d_lit ? S_WRITE : S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          produced <= produced + OSIZE_W'(1);
          pack_data[{pack_cnt[2:0], 3'b000} +: 8] <= wr_byte;
          pack_cnt <= pack_cnt + 4'd1;
          rem      <= rem - REM_W'(1);
          if (rem == REM_W'(1)) begin
            run_last <= 1'b1;
            state    <= S_FLUSH;
          end else if (pack_cnt == 4'(BYTES_PER_RESULT - 1)) begin
            state <= S_FLUSH;
          end else begin
            state <= S_READ;
          end
        end
        S_FLUSH: begin
          if (out_load) begin
            pack_data <= '0;
            pack_cnt  <= '0;
            state     <= run_last ? S_IDLE : S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Per-command payload: copy source, literal and status for every beat
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      copy_addr <= produced[AW-1:0] - dist_sel[AW-1:0];
      is_lit    <= d_lit;
      lit_val   <= cmd.word[7:0];
      res_kind  <= expect_kind_next;
      res_done  <= finished_next;
      res_err   <= d_err;
    end else if (state == S_READ) begin
      copy_addr <= copy_addr + AW'(1);
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      result.data_bytes  <= pack_data;
      result.byte_count  <= pack_cnt;
      result.last_of_run <= run_last;
      result.next_kind   <= res_kind;
      result.done_res    <= res_done;
      result.error       <= res_err;
    end
  end

  assign result.valid = out_valid;

  `ASSERT_NEVER(a_pack_bound, pack_cnt > 4'(BYTES_PER_RESULT), "pack overflow")
  `ASSERT_CLK(a_write_has_work, (state == S_WRITE) |-> (rem != '0), "write with no bytes left")
  `ASSERT_CLK(a_done_sticky, finished |=> finished, "finish flag dropped")
  `ASSERT_CLK(a_flush_holds, (state == S_FLUSH) && !out_load |=> (state == S_FLUSH),
              "flush left without loading a beat")

endmodule

// ===== rtl/core/lz_mask_link_decompressor.sv =====
// Top level of the mask/link LZ decompressor: front queue plus back executor.
// Depends on lzd_pkg, lzd_item_if, lzd_result_if, lzd_front, lzd_back.
//
//   channel   dir  beat
//   item      in   one stream element (op, value)
//   result    out  up to eight decoded bytes plus status
//   cfg       in   output_size write (cfg_we, cfg_wdata)
//
// An element with no bytes (mask word, pending link, wrong kind, finished) goes
// from idle straight to the flush state in the back; a literal writes its byte
// first; a copy reads and then writes the history RAM once per byte.
// While a stalled sink holds the result register, the back waits in flush.
// Reset clears all control state; the history RAM is not cleared.
// A two-entry queue lets the front keep taking elements while results stall.
`timescale 1ns / 1ps
module lz_mask_link_decompressor import lzd_pkg::*; #(
  parameter int HISTORY_DEPTH    = HISTORY_DEPTH_DEF,
  parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [OSIZE_W-1:0] cfg_wdata,
  lzd_item_if.sink           item,
  lzd_result_if.source       result
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  lzd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  lzd_back #(
    .HISTORY_DEPTH    (HISTORY_DEPTH),
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .result    (result)
  );

endmodule

// ===== tb/lzd_tb_pkg.sv =====
// Shared testbench types for the decompressor bench: the expected result beat.
// Depends on nothing.
`timescale 1ns / 1ps
package lzd_tb_pkg;

  typedef struct packed {
    logic [63:0] data_bytes;
    logic [3:0]  byte_count;
    logic        last_of_run;
    logic [1:0]  next_kind;
    logic        done_res;
    logic [1:0]  error;
  } beat_t;

endpackage

// ===== tb/lzd_checker.sv =====
// Scoreboard for the decompressor: mirrors the decode state, predicts the result
// beats of every accepted element and compares them. Depends on lzd_pkg, lzd_tb_pkg.
`timescale 1ns / 1ps
module lzd_checker import lzd_pkg::*; import lzd_tb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [OSIZE_W-1:0] cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [31:0]        in_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  beat_t              out_beat,
  output int                 fail_count,
  output int                 pending
);

  logic [7:0]         hist [HISTORY_DEPTH_DEF];
  logic [OSIZE_W-1:0] size_limit;
  logic [OSIZE_W-1:0] produced;
  logic [31:0]        bits;
  logic [5:0]         bits_left;
  logic [DIST_W-1:0]  held_dist;
  logic [1:0]         want_kind;
  logic               done_flag;
  beat_t              expected_beats [$];
  logic [7:0]         run_bytes [$];

  assign pending = expected_beats.size();

  function automatic logic [OSIZE_W-1:0] room();
    return (size_limit > produced) ? size_limit - produced : '0;
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    hist[produced[11:0]] = b;
    produced = produced + 1'b1;
    run_bytes.push_back(b);
  endfunction

  function automatic logic [1:0] copy_run(logic [DIST_W-1:0] cp_dist, int len);
    int n;
    if (cp_dist == 0 || OSIZE_W'(cp_dist) > produced) return ERR_DIST;
    n = (len > room()) ? int'(room()) : len;
    for (int i = 0; i < n; i++) emit_byte(hist[12'(produced - OSIZE_W'(cp_dist))]);
    return ERR_NONE;
  endfunction

  function automatic void consume_bit();
    bits = bits << 1;
    if (bits_left > 0) bits_left--;
    if (bits_left == 0) want_kind = KIND_MASK;
    else want_kind = bits[31] ? KIND_LIT : KIND_LINK;
    if (produced >= size_limit) done_flag = 1'b1;
  endfunction

  // Advance the decode state for one element and queue its beats
  function automatic void predict_element(logic [1:0] op, logic [31:0] v);
    logic [1:0] err;
    int nb, total;
    beat_t b;
    err = ERR_NONE;
    run_bytes.delete();
    if (done_flag) begin
    end else if (op != want_kind) begin
      err = ERR_KIND;
    end else begin
      case (op)
        KIND_MASK: begin
          bits = v;
          bits_left = 6'd32;
          want_kind = v[31] ? KIND_LIT : KIND_LINK;
        end
        KIND_LIT: begin
          if (room() > 0) emit_byte(v[7:0]);
          consume_bit();
        end
        KIND_LINK: begin
          if (v[15:12] == 4'd0) begin
            held_dist = {1'b0, v[11:0]} + 1'b1;
            want_kind = KIND_COUNT;
          end else begin
            err = copy_run({1'b0, v[11:0]} + 1'b1, int'(v[15:12]) + 2);
            consume_bit();
          end
        end
        default: begin
          err = copy_run(held_dist, int'(v[7:0]) + 18);
          consume_bit();
        end
      endcase
    end
    nb = run_bytes.size();
    total = (nb == 0) ? 1 : (nb + 7) / 8;
    for (int k = 0; k < total; k++) begin
      b = '0;
      for (int j = 0; j < 8 && k * 8 + j < nb; j++) begin
        b.data_bytes[8*j +: 8] = run_bytes[k*8 + j];
        b.byte_count++;
      end
      b.last_of_run = (k == total - 1);
      b.next_kind = want_kind;
      b.done_res = done_flag;
      b.error = err;
      expected_beats.push_back(b);
    end
  endfunction

  // Track config, predict on input beats, compare on output beats
  always @(posedge clk) begin
    beat_t e;
    if (rst) begin
      size_limit = '0; produced = '0; bits = '0; bits_left = '0;
      held_dist = '0; want_kind = KIND_MASK; done_flag = 1'b0;
      expected_beats.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) size_limit = cfg_wdata;
      if (in_valid && in_ready) predict_element(in_op, in_value);
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_beats.pop_front();
          if (out_beat !== e) begin
            fail_count <= fail_count + 1;
            if (out_beat.data_bytes !== e.data_bytes)
              $error("data_bytes exp %h got %h", e.data_bytes, out_beat.data_bytes);
            if (out_beat.byte_count !== e.byte_count)
              $error("byte_count exp %0d got %0d", e.byte_count, out_beat.byte_count);
            if (out_beat.last_of_run !== e.last_of_run)
              $error("last_of_run exp %0d got %0d", e.last_of_run, out_beat.last_of_run);
            if (out_beat.next_kind !== e.next_kind)
              $error("next_kind exp %0d got %0d", e.next_kind, out_beat.next_kind);
            if (out_beat.done_res !== e.done_res)
              $error("done_res exp %0d got %0d", e.done_res, out_beat.done_res);
            if (out_beat.error !== e.error)
              $error("error exp %0d got %0d", e.error, out_beat.error);
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
// Top of the decompressor bench: clock, reset, element stimulus and verdict.
// Depends on lzd_pkg, lzd_tb_pkg, the channel interfaces, lzd_checker and the RTL.
`timescale 1ns / 1ps
module tb;
  import lzd_pkg::*;
  import lzd_tb_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [OSIZE_W-1:0] cfg_wdata = '0;
  logic quiet = 1'b0;
  int fail_count, pending;
  int idle_cycles = 0;
  // Sender-side mirror of the stream shape, used to build well-formed elements
  logic [1:0] gen_kind;
  logic [31:0] gen_bits;
  int gen_left, gen_produced, gen_dist;

  lzd_item_if item ();
  lzd_result_if result ();

  always #5 clk = ~clk;

  lz_mask_link_decompressor uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .item(item), .result(result)
  );

  lzd_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(item.valid), .in_ready(item.ready), .in_op(item.op), .in_value(item.value),
    .out_valid(result.valid), .out_ready(result.ready),
    .out_beat({result.data_bytes, result.byte_count, result.last_of_run,
               result.next_kind, result.done_res, result.error}),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: random stall bursts, none in the quiet tail
  initial begin
    int n;
    result.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 13);
        result.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result.ready <= 1'b1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk);
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((item.valid && item.ready) || (result.valid && result.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_element(logic [1:0] op, logic [31:0] v);
    int gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
    if (gap != 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.valid <= 1'b1;
    item.op <= op;
    item.value <= v;
    do @(posedge clk); while (!item.ready);
  endtask

  // Drop valid, drain everything in flight, then write the size register
  task automatic write_size(int unsigned sz);
    item.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= OSIZE_W'(sz);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Pick one well-formed element for the current stream position
  task automatic send_formed();
    logic [31:0] v;
    logic [1:0] op;
    op = gen_kind;
    v = $urandom;
    case (gen_kind)
      KIND_MASK: begin
        gen_bits = v; gen_left = 32;
        gen_kind = v[31] ? KIND_LIT : KIND_LINK;
      end
      KIND_LIT: gen_produced++;
      KIND_LINK: begin
        gen_dist = (gen_produced < 1) ? 1
                 : $urandom_range(1, gen_produced > 4096 ? 4096 : gen_produced);
        if ($urandom_range(0, 9) == 0) gen_dist = $urandom_range(1, 4096);
        v[11:0] = 12'(gen_dist - 1);
        if ($urandom_range(0, 4) == 0) v[15:12] = 4'd0;
        else if (v[15:12] == 0) v[15:12] = 4'd1;
      end
      default: begin
        if ($urandom_range(0, 1) == 0) v[7:0] = 8'($urandom_range(0, 15));
      end
    endcase
    if (op == KIND_LINK && v[15:12] == 4'd0) gen_kind = KIND_COUNT;
    else if (op != KIND_MASK) begin
      if (op == KIND_LINK || op == KIND_COUNT) begin
        if (gen_dist <= gen_produced)
          gen_produced += (op == KIND_COUNT) ? 18 + v[7:0] : v[15:12] + 2;
      end
      gen_bits = gen_bits << 1;
      gen_left--;
      gen_kind = (gen_left == 0) ? KIND_MASK : (gen_bits[31] ? KIND_LIT : KIND_LINK);
    end
    send_element(op, v);
  endtask

  function automatic void rst_model();
    gen_kind = KIND_MASK; gen_bits = '0; gen_left = 0; gen_produced = 0; gen_dist = 0;
  endfunction

  initial begin
    item.valid = 1'b0; item.op = KIND_MASK; item.value = '0;
    rst_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Wide size so the random streams never reach the end
    write_size(25'h100_0000);
    // A literal where a mask word is due is dropped with a kind error
    send_element(KIND_LIT, 32'h0000_00aa);
    repeat (380) send_formed();

    // Cut the size near the current count so the decode finishes mid-stream
    quiet = 1'b1;
    write_size(gen_produced + 60);
    repeat (50) send_formed();

    // A finished decoder ignores everything, extreme values included
    send_element(KIND_LINK, 32'hffff_ffff);
    send_element(KIND_LINK, 32'h0000_0000);
    repeat (20) send_element(2'($urandom_range(0, 3)), $urandom);
    // Raising the size does not revive a finished decode
    write_size(25'h100_0000);
    send_element(KIND_MASK, 32'h0);
    item.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
